/* hdl/diff_drive_odometry_core_assert.svh */
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Concurrent assertion wrappers shared by the odometry RTL; empty when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge outside reset
`define DDO_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("odometry assertion failed");

// antecedent in one cycle implies consequent in the next
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry sequencing assertion failed");

`else

`define DDO_ASSERT(lbl, clk, rst_n, prop)
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// Odometry package
// Shared types, register codes, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // default fixed-point formats
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;

    // configuration port
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_LEFT_CPR  = 2'd0;
    localparam logic [1:0] REG_RIGHT_CPR = 2'd1;
    localparam logic [1:0] REG_RADIUS    = 2'd2;
    localparam logic [1:0] REG_BASE      = 2'd3;

    localparam logic [15:0] LEFT_CPR_RST  = 16'd1656;
    localparam logic [15:0] RIGHT_CPR_RST = 16'd1656;
    localparam logic [19:0] RADIUS_RST    = 20'd70000;
    localparam logic [23:0] BASE_RST      = 24'd440000;

    // arithmetic constants
    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE60      = 64'h1000000000000000;
    localparam logic [63:0] CAP63      = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [63:0] CAP62      = 64'h4000000000000000;
    localparam logic [63:0] MICRO      = 64'd1000000;
    localparam logic [63:0] POS_DIV    = 64'd256000000;
    localparam logic signed [63:0] S32_MAX = 64'sh000000007FFFFFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFFFFFF80000000;

    typedef struct packed {
        logic [15:0] left_cpr;
        logic [15:0] right_cpr;
        logic [19:0] radius;
        logic [23:0] base;
    } cfg_t;

    // magnitude of a 64-bit two's complement value
    function automatic logic [63:0] mag64(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // cap magnitude at 2^62 and apply sign
    function automatic logic signed [63:0] apply_sign(logic [63:0] m, logic neg);
        logic [63:0] mm;
        mm = (m > CAP62) ? CAP62 : m;
        return neg ? $signed(64'd0 - mm) : $signed(mm);
    endfunction

    function automatic logic [31:0] sat32(logic signed [63:0] v);
        logic [31:0] r;
        if (v > S32_MAX)
            r = 32'h7FFFFFFF;
        else if (v < S32_MIN)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // saturating position accumulate
    function automatic logic [31:0] pos_add(logic [31:0] acc, logic [63:0] m, logic neg);
        logic signed [63:0] sum;
        sum = $signed({{32{acc[31]}}, acc}) + apply_sign(m, neg);
        return sat32(sum);
    endfunction

    // Taylor term divisors: (2k-1)(2k) for cosine, (2k)(2k+1) for sine
    function automatic logic [63:0] cos_div(logic [2:0] k);
        logic [63:0] r;
        case (k)
            3'd1:    r = 64'd2;
            3'd2:    r = 64'd12;
            3'd3:    r = 64'd30;
            3'd4:    r = 64'd56;
            3'd5:    r = 64'd90;
            3'd6:    r = 64'd132;
            default: r = 64'd1;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] sin_div(logic [2:0] k);
        logic [63:0] r;
        case (k)
            3'd1:    r = 64'd6;
            3'd2:    r = 64'd20;
            3'd3:    r = 64'd42;
            3'd4:    r = 64'd72;
            3'd5:    r = 64'd110;
            3'd6:    r = 64'd156;
            default: r = 64'd1;
        endcase
        return r;
    endfunction

endpackage

/* hdl/ddo_in_if.sv */
// ----------------------------------------------------------------------------
// Odometry input channel
// Valid/ready channel carrying encoder counts and elapsed time.
// ----------------------------------------------------------------------------
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic        [19:0] elapsed_us;

    modport source (output valid, left_count, right_count, elapsed_us, input ready);
    modport sink   (input valid, left_count, right_count, elapsed_us, output ready);
endinterface

/* hdl/ddo_out_if.sv */
// ----------------------------------------------------------------------------
// Odometry output channel
// Valid/ready channel carrying pose and velocity.
// ----------------------------------------------------------------------------
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic signed [31:0] lin_vel;
    logic signed [31:0] ang_vel;

    modport source (output valid, pos_x, pos_y, heading, lin_vel, ang_vel, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, lin_vel, ang_vel, output ready);
endinterface

/* hdl/ddo_muldiv.sv */
// ----------------------------------------------------------------------------
// Odometry multiply-divide unit
// round(a*b/c) on the full 128-bit product: four 32x32 partial products,
// then a restoring divide one quotient bit per cycle. Saturates at 2^63-1.
// ----------------------------------------------------------------------------
`include "diff_drive_odometry_core_assert.svh"

module ddo_muldiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] c,
    output logic        busy,
    output logic        done,
    output logic [63:0] quot,
    output logic [63:0] low
);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_HALF = 2'd2;
    localparam logic [1:0] U_DIV  = 2'd3;

    logic [1:0]   phase_reg;
    logic [6:0]   step_reg;
    logic         done_reg;
    logic [63:0]  a_reg, b_reg, c_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [127:0] prod_reg;
    logic [63:0]  rem_reg;

    logic [31:0]  a_part, b_part;
    logic [127:0] pp_shift;
    logic [64:0]  rem_sh;
    logic         q_bit;
    logic [64:0]  rem_diff;

    // operand halves for the current partial product
    assign a_part   = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_part   = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp_shift = {64'd0, pp_reg} << {sh_reg, 5'd0};

    // one restoring divide step
    assign rem_sh   = {rem_reg, prod_reg[127]};
    assign q_bit    = rem_sh >= {1'b0, c_reg};
    assign rem_diff = rem_sh - {1'b0, c_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= U_IDLE;
            step_reg  <= 7'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= U_MUL;
                        step_reg  <= 7'd0;
                    end
                end
                U_MUL:
                begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd4)
                        phase_reg <= U_HALF;
                end
                U_HALF:
                begin
                    phase_reg <= U_DIV;
                    step_reg  <= 7'd0;
                end
                U_DIV:
                begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd127)
                    begin
                        phase_reg <= U_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                    phase_reg <= U_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    a_reg    <= a;
                    b_reg    <= b;
                    c_reg    <= (c == 64'd0) ? 64'd1 : c;
                    prod_reg <= 128'd0;
                end
            end
            U_MUL:
            begin
                if (step_reg < 7'd4)
                begin
                    pp_reg <= a_part * b_part;
                    sh_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
                end
                if (step_reg != 7'd0)
                    prod_reg <= prod_reg + pp_shift;
            end
            U_HALF:
            begin
                prod_reg <= prod_reg + {65'd0, c_reg[63:1]};
                rem_reg  <= 64'd0;
            end
            U_DIV:
            begin
                rem_reg  <= q_bit ? rem_diff[63:0] : rem_sh[63:0];
                prod_reg <= {prod_reg[126:0], q_bit};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign busy = phase_reg != U_IDLE;
    assign done = done_reg;
    assign low  = prod_reg[63:0];
    assign quot = (prod_reg[127:63] != 65'd0) ? ddo_pkg::CAP63 : prod_reg[63:0];

    `DDO_ASSERT(a_start_idle, clk, rst_n, start |-> !busy)
    `DDO_ASSERT(a_rem_below, clk, rst_n, (phase_reg == U_DIV) |-> (rem_reg < c_reg))
    `DDO_ASSERT(a_done_idle, clk, rst_n, done_reg |-> (phase_reg == U_IDLE))

endmodule

/* hdl/ddo_cfg.sv */
// ----------------------------------------------------------------------------
// Odometry configuration registers
// APB-style register file for wheel geometry; writes in the access phase.
// ----------------------------------------------------------------------------
module ddo_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output ddo_pkg::cfg_t             cfg
);

    ddo_pkg::cfg_t cfg_reg;
    logic [1:0]    idx;

    assign idx = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_cpr  <= ddo_pkg::LEFT_CPR_RST;
            cfg_reg.right_cpr <= ddo_pkg::RIGHT_CPR_RST;
            cfg_reg.radius    <= ddo_pkg::RADIUS_RST;
            cfg_reg.base      <= ddo_pkg::BASE_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                ddo_pkg::REG_LEFT_CPR:  cfg_reg.left_cpr  <= pwdata[15:0];
                ddo_pkg::REG_RIGHT_CPR: cfg_reg.right_cpr <= pwdata[15:0];
                ddo_pkg::REG_RADIUS:    cfg_reg.radius    <= pwdata[19:0];
                ddo_pkg::REG_BASE:      cfg_reg.base      <= pwdata[23:0];
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (idx)
            ddo_pkg::REG_LEFT_CPR:  prdata = {16'd0, cfg_reg.left_cpr};
            ddo_pkg::REG_RIGHT_CPR: prdata = {16'd0, cfg_reg.right_cpr};
            ddo_pkg::REG_RADIUS:    prdata = {12'd0, cfg_reg.radius};
            ddo_pkg::REG_BASE:      prdata = {8'd0, cfg_reg.base};
            default:                prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

/* hdl/diff_drive_odometry_core.sv */
// ----------------------------------------------------------------------------
// Differential-drive odometry core
// Wheel odometry: velocities, dead-reckoned position and wrapping heading.
// ----------------------------------------------------------------------------
// Usage:
//   din  : valid/ready item of absolute left/right encoder counts and the
//          elapsed time in microseconds. Accepted when valid and ready.
//   dout : valid/ready item of pos_x, pos_y (Q16.16 m), heading (binary
//          angle), lin_vel (m/s) and ang_vel (rad/s), one per input item.
//   APB  : wheel counts per revolution, radius and base, written while idle.
// Each item is worked through 42 multiply-divide operations on one shared
// unit (an issue step, the partial products, a rounding step, a bit-serial
// divide and a done strobe for each), plus a step to unfold the trig terms
// and one to load the output register. A new item is accepted only after the
// last one has moved into the output register; ready is high only between
// items.
// The result sits in an output register; a new item may be accepted while it
// waits, and if the receiver stalls the next result is held back until the
// register is free.
// Reset clears position, heading and the previous counts, and loads the
// default wheel geometry.
// ----------------------------------------------------------------------------
`include "diff_drive_odometry_core_assert.svh"

module diff_drive_odometry_core #(
    parameter int FRAC_BITS  = ddo_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ddo_in_if.sink                     din,
    ddo_out_if.source                  dout,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_P1   = 5'd1;
    localparam logic [4:0] S_P2   = 5'd2;
    localparam logic [4:0] S_DEN  = 5'd3;
    localparam logic [4:0] S_G    = 5'd4;
    localparam logic [4:0] S_D    = 5'd5;
    localparam logic [4:0] S_LIN  = 5'd6;
    localparam logic [4:0] S_H    = 5'd7;
    localparam logic [4:0] S_HP   = 5'd8;
    localparam logic [4:0] S_BDT  = 5'd9;
    localparam logic [4:0] S_ANG  = 5'd10;
    localparam logic [4:0] S_DENB = 5'd11;
    localparam logic [4:0] S_WRAP = 5'd12;
    localparam logic [4:0] S_TX   = 5'd13;
    localparam logic [4:0] S_TX2  = 5'd14;
    localparam logic [4:0] S_TC1  = 5'd15;
    localparam logic [4:0] S_TC2  = 5'd16;
    localparam logic [4:0] S_TS1  = 5'd17;
    localparam logic [4:0] S_TS2  = 5'd18;
    localparam logic [4:0] S_TRIG = 5'd19;
    localparam logic [4:0] S_EX   = 5'd20;
    localparam logic [4:0] S_MX   = 5'd21;
    localparam logic [4:0] S_EY   = 5'd22;
    localparam logic [4:0] S_MY   = 5'd23;
    localparam logic [4:0] S_OUT  = 5'd24;

    localparam logic [63:0] FRAC_ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] MICRO_FR  = ddo_pkg::MICRO << FRAC_BITS;
    localparam int          HEAD_SHIFT = 32 - ANGLE_BITS;

    ddo_pkg::cfg_t cfg;

    logic [4:0]  pc_reg;
    logic        issued_reg;
    logic [2:0]  k_reg;

    // model state
    logic [31:0] prev_l_reg, prev_r_reg;
    logic [31:0] acc_x_reg, acc_y_reg, acc_heading_reg;

    // working registers
    logic [31:0]        dl_reg, dr_reg;
    logic [19:0]        dt_reg;
    logic [63:0]        p1_reg, den_reg, g_reg, d_reg, h_reg, hp_reg;
    logic [63:0]        bdt_reg, denb_reg, x_reg, x2_reg, tc_reg, ts_reg, e_reg;
    logic signed [63:0] nsum_reg, ndiff_reg, s_acc_reg, c_acc_reg;
    logic [31:0]        lin_reg, ang_reg, dh_reg, cs_reg, sn_reg;

    // output register
    logic               out_valid_reg;
    logic [31:0]        ox_reg, oy_reg, olin_reg, oang_reg;
    logic [15:0]        ohead_reg;
    logic               out_load;

    // shared unit
    logic        u_start, u_busy, u_done;
    logic [63:0] op_a, op_b, op_c, u_q, u_low;
    logic        op_state;

    logic [63:0] cl_e, cr_e, b_e, r_e, dt_e;
    logic [29:0] oct_f;
    logic        oct_swap;
    logic [63:0] oct_g;
    logic [63:0] s_rnd, c_rnd;
    logic [31:0] s30, c30, t_co, t_si;
    logic [63:0] sp1, sp2;
    logic [31:0] head_sh;

    ddo_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddo_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .start (u_start),
        .a     (op_a),
        .b     (op_b),
        .c     (op_c),
        .busy  (u_busy),
        .done  (u_done),
        .quot  (u_q),
        .low   (u_low)
    );

    // effective geometry: zero counts or base read as one
    assign cl_e = (cfg.left_cpr == 16'd0) ? 64'd1 : {48'd0, cfg.left_cpr};
    assign cr_e = (cfg.right_cpr == 16'd0) ? 64'd1 : {48'd0, cfg.right_cpr};
    assign b_e  = (cfg.base == 24'd0) ? 64'd1 : {40'd0, cfg.base};
    assign r_e  = {44'd0, cfg.radius};
    assign dt_e = {44'd0, dt_reg};

    // octant fold of the old heading
    assign oct_f    = acc_heading_reg[29:0];
    assign oct_swap = oct_f > 30'h20000000;
    assign oct_g    = oct_swap ? (64'h40000000 - {34'd0, oct_f}) : {34'd0, oct_f};

    // Q60 to Q30 with rounding, then unfold to the quadrant
    assign s_rnd = s_acc_reg + 64'h20000000;
    assign c_rnd = c_acc_reg + 64'h20000000;
    assign s30   = oct_swap ? c_rnd[61:30] : s_rnd[61:30];
    assign c30   = oct_swap ? s_rnd[61:30] : c_rnd[61:30];

    always_comb
    begin
        case (acc_heading_reg[31:30])
            2'd0:    begin t_co = c30;          t_si = s30;          end
            2'd1:    begin t_co = 32'd0 - s30;  t_si = c30;          end
            2'd2:    begin t_co = 32'd0 - c30;  t_si = 32'd0 - s30;  end
            default: begin t_co = s30;          t_si = 32'd0 - c30;  end
        endcase
    end

    // signed wheel products
    assign sp1 = dr_reg[31] ? (64'd0 - p1_reg) : p1_reg;
    assign sp2 = dl_reg[31] ? (64'd0 - u_q) : u_q;

    // operand selection for the shared unit
    always_comb
    begin
        op_a = 64'd0;
        op_b = 64'd0;
        op_c = 64'd1;
        case (pc_reg)
            S_P1:   begin op_a = ddo_pkg::mag64({{32{dr_reg[31]}}, dr_reg}); op_b = cl_e; end
            S_P2:   begin op_a = ddo_pkg::mag64({{32{dl_reg[31]}}, dl_reg}); op_b = cr_e; end
            S_DEN:  begin op_a = cl_e; op_b = cr_e; end
            S_G:    begin op_a = ddo_pkg::mag64(nsum_reg); op_b = r_e << 8; op_c = den_reg; end
            S_D:    begin op_a = g_reg; op_b = ddo_pkg::PI_Q60; op_c = ddo_pkg::ONE60; end
            S_LIN:  begin op_a = d_reg; op_b = FRAC_ONE; op_c = dt_e << 8; end
            S_H:    begin op_a = ddo_pkg::mag64(ndiff_reg); op_b = r_e << 8; op_c = den_reg; end
            S_HP:   begin op_a = h_reg; op_b = ddo_pkg::TWO_PI_Q60; op_c = ddo_pkg::ONE60; end
            S_BDT:  begin op_a = b_e << 8; op_b = dt_e; end
            S_ANG:  begin op_a = hp_reg; op_b = MICRO_FR; op_c = bdt_reg; end
            S_DENB: begin op_a = den_reg; op_b = b_e; end
            S_WRAP: begin op_a = ddo_pkg::mag64(ndiff_reg); op_b = r_e << 32; op_c = denb_reg; end
            S_TX:   begin op_a = oct_g; op_b = ddo_pkg::PI_Q60; op_c = 64'd1 << 31; end
            S_TX2:  begin op_a = x_reg; op_b = x_reg; op_c = ddo_pkg::ONE60; end
            S_TC1:  begin op_a = tc_reg; op_b = x2_reg; op_c = ddo_pkg::ONE60; end
            S_TC2:  begin op_a = tc_reg; op_b = 64'd1; op_c = ddo_pkg::cos_div(k_reg); end
            S_TS1:  begin op_a = ts_reg; op_b = x2_reg; op_c = ddo_pkg::ONE60; end
            S_TS2:  begin op_a = ts_reg; op_b = 64'd1; op_c = ddo_pkg::sin_div(k_reg); end
            S_EX:   begin op_a = d_reg; op_b = ddo_pkg::mag64({{32{cs_reg[31]}}, cs_reg});
                          op_c = 64'd1 << 30; end
            S_MX:   begin op_a = e_reg; op_b = FRAC_ONE; op_c = ddo_pkg::POS_DIV; end
            S_EY:   begin op_a = d_reg; op_b = ddo_pkg::mag64({{32{sn_reg[31]}}, sn_reg});
                          op_c = 64'd1 << 30; end
            S_MY:   begin op_a = e_reg; op_b = FRAC_ONE; op_c = ddo_pkg::POS_DIV; end
            default: op_c = 64'd1;
        endcase
    end

    assign op_state = !(pc_reg inside {S_IDLE, S_TRIG, S_OUT});
    assign u_start  = op_state && !issued_reg;

    assign din.ready = pc_reg == S_IDLE;
    assign head_sh   = acc_heading_reg >> HEAD_SHIFT;

    // result moves into the output register once it is free
    assign out_load = (pc_reg == S_OUT) && (!out_valid_reg || dout.ready);

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= S_IDLE;
            issued_reg      <= 1'b0;
            k_reg           <= 3'd1;
            out_valid_reg   <= 1'b0;
            prev_l_reg      <= 32'd0;
            prev_r_reg      <= 32'd0;
            acc_x_reg       <= 32'd0;
            acc_y_reg       <= 32'd0;
            acc_heading_reg <= 32'd0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && dout.ready)
                out_valid_reg <= 1'b0;
            if (u_start)
                issued_reg <= 1'b1;

            case (pc_reg)
                S_IDLE:
                begin
                    if (din.valid)
                    begin
                        prev_l_reg <= din.left_count;
                        prev_r_reg <= din.right_count;
                        pc_reg     <= S_P1;
                    end
                end
                S_TRIG:
                    pc_reg <= S_EX;
                S_OUT:
                begin
                    if (out_load)
                        pc_reg <= S_IDLE;
                end
                default:
                begin
                    if (issued_reg && u_done)
                    begin
                        issued_reg <= 1'b0;
                        case (pc_reg)
                            S_P1:    pc_reg <= S_P2;
                            S_P2:    pc_reg <= S_DEN;
                            S_DEN:   pc_reg <= S_G;
                            S_G:     pc_reg <= S_D;
                            S_D:     pc_reg <= S_LIN;
                            S_LIN:   pc_reg <= S_H;
                            S_H:     pc_reg <= S_HP;
                            S_HP:    pc_reg <= S_BDT;
                            S_BDT:   pc_reg <= S_ANG;
                            S_ANG:   pc_reg <= S_DENB;
                            S_DENB:  pc_reg <= S_WRAP;
                            S_WRAP:  pc_reg <= S_TX;
                            S_TX:
                            begin
                                k_reg  <= 3'd1;
                                pc_reg <= S_TX2;
                            end
                            S_TX2:   pc_reg <= S_TC1;
                            S_TC1:   pc_reg <= S_TC2;
                            S_TC2:   pc_reg <= S_TS1;
                            S_TS1:   pc_reg <= S_TS2;
                            S_TS2:
                            begin
                                if (k_reg == 3'd6)
                                    pc_reg <= S_TRIG;
                                else
                                begin
                                    k_reg  <= k_reg + 3'd1;
                                    pc_reg <= S_TC1;
                                end
                            end
                            S_EX:    pc_reg <= S_MX;
                            S_MX:
                            begin
                                acc_x_reg <= ddo_pkg::pos_add(acc_x_reg, u_q,
                                                              nsum_reg[63] ^ cs_reg[31]);
                                pc_reg    <= S_EY;
                            end
                            S_EY:    pc_reg <= S_MY;
                            S_MY:
                            begin
                                acc_y_reg       <= ddo_pkg::pos_add(acc_y_reg, u_q,
                                                                    nsum_reg[63] ^ sn_reg[31]);
                                acc_heading_reg <= acc_heading_reg + dh_reg;
                                pc_reg          <= S_OUT;
                            end
                            default: pc_reg <= S_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (pc_reg == S_IDLE && din.valid)
        begin
            dl_reg <= din.left_count - prev_l_reg;
            dr_reg <= din.right_count - prev_r_reg;
            dt_reg <= (din.elapsed_us == 20'd0) ? 20'd1 : din.elapsed_us;
        end
        if (pc_reg == S_TRIG)
        begin
            cs_reg <= t_co;
            sn_reg <= t_si;
        end
        if (out_load)
        begin
            ox_reg    <= acc_x_reg;
            oy_reg    <= acc_y_reg;
            ohead_reg <= head_sh[15:0];
            olin_reg  <= lin_reg;
            oang_reg  <= ang_reg;
        end
        if (issued_reg && u_done)
        begin
            case (pc_reg)
                S_P1:  p1_reg <= u_q;
                S_P2:
                begin
                    nsum_reg  <= $signed(sp1 + sp2);
                    ndiff_reg <= $signed(sp1 - sp2);
                end
                S_DEN:  den_reg <= u_q;
                S_G:    g_reg   <= u_q;
                S_D:    d_reg   <= u_q;
                S_LIN:  lin_reg <= ddo_pkg::sat32(ddo_pkg::apply_sign(u_q, nsum_reg[63]));
                S_H:    h_reg   <= u_q;
                S_HP:   hp_reg  <= u_q;
                S_BDT:  bdt_reg <= u_q;
                S_ANG:  ang_reg <= ddo_pkg::sat32(ddo_pkg::apply_sign(u_q, ndiff_reg[63]));
                S_DENB: denb_reg <= u_q;
                S_WRAP: dh_reg  <= ndiff_reg[63] ? (32'd0 - u_low[31:0]) : u_low[31:0];
                S_TX:
                begin
                    x_reg     <= u_q;
                    ts_reg    <= u_q;
                    s_acc_reg <= $signed(u_q);
                    tc_reg    <= ddo_pkg::ONE60;
                    c_acc_reg <= $signed(ddo_pkg::ONE60);
                end
                S_TX2:  x2_reg <= u_q;
                S_TC1:  tc_reg <= u_q;
                S_TC2:
                begin
                    tc_reg    <= u_q;
                    c_acc_reg <= k_reg[0] ? (c_acc_reg - $signed(u_q))
                                          : (c_acc_reg + $signed(u_q));
                end
                S_TS1:  ts_reg <= u_q;
                S_TS2:
                begin
                    ts_reg    <= u_q;
                    s_acc_reg <= k_reg[0] ? (s_acc_reg - $signed(u_q))
                                          : (s_acc_reg + $signed(u_q));
                end
                S_EX:   e_reg <= u_q;
                S_EY:   e_reg <= u_q;
                default: e_reg <= e_reg;
            endcase
        end
    end

    // output channel
    assign dout.valid   = out_valid_reg;
    assign dout.pos_x   = ox_reg;
    assign dout.pos_y   = oy_reg;
    assign dout.heading = ohead_reg;
    assign dout.lin_vel = olin_reg;
    assign dout.ang_vel = oang_reg;

    `DDO_ASSERT_NEXT(a_accept_start, clk, rst_n, din.valid && din.ready, pc_reg == S_P1)
    `DDO_ASSERT(a_loop_k, clk, rst_n, (pc_reg == S_TC1) |-> (k_reg >= 3'd1 && k_reg <= 3'd6))
    `DDO_ASSERT(a_out_load, clk, rst_n, $rose(out_valid_reg) |-> (pc_reg == S_IDLE))
    `DDO_ASSERT(a_unit_idle, clk, rst_n, (pc_reg == S_IDLE) |-> !u_busy)

endmodule
